>>> hdl/jmss_pkg.sv
// ============================================================================
// jmss_pkg
// Shared types and constants of the jpeg marker scan splitter: byte and
// record beats, the event passed from the scanner to the output stage.
// ============================================================================
package jmss_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] SOI_CODE  = 8'hD8;
    localparam logic [7:0] EOI_CODE  = 8'hD9;
    localparam logic [7:0] RST0_CODE = 8'hD0;
    localparam logic [7:0] RST7_CODE = 8'hD7;
    localparam logic [OFFSET_BITS-1:0] FOURTH_BYTE_POS = OFFSET_BITS'(3);

    localparam logic [1:0] STATUS_SHORT = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_BASE  = 2'd2;
    localparam logic [1:0] STATUS_BOTH  = 2'd3;

    localparam logic KIND_MARKER  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } byte_item_t;

    typedef struct packed {
        logic                   record_kind;
        logic [7:0]             marker_code;
        logic [OFFSET_BITS-1:0] marker_offset;
        logic [15:0]            segment_length;
        logic [OFFSET_BITS-1:0] first_start;
        logic [OFFSET_BITS-1:0] first_end;
        logic [OFFSET_BITS-1:0] second_start;
        logic [OFFSET_BITS-1:0] second_end;
        logic [1:0]             status;
        logic                   last_of_run;
    } rec_item_t;

    // one accepted byte that produced output: a marker, a summary or both
    typedef struct packed {
        logic                   has_marker;
        logic [7:0]             marker_code;
        logic [OFFSET_BITS-1:0] marker_offset;
        logic [15:0]            segment_length;
        logic                   has_summary;
        logic [OFFSET_BITS-1:0] first_start;
        logic [OFFSET_BITS-1:0] first_end;
        logic [OFFSET_BITS-1:0] second_start;
        logic [OFFSET_BITS-1:0] second_end;
        logic [1:0]             status;
    } scan_event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/jmss_front.sv
// ============================================================================
// jmss_front
// Byte scanner: tracks marker, length and skip phases, keeps SOI/EOI
// positions and builds one event per byte that yields output.
// ============================================================================
module jmss_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  jmss_pkg::byte_item_t   byte_item,
    input  jmss_pkg::queue_status_t q_status,
    output logic                   push,
    output jmss_pkg::scan_event_t  push_event
);

    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_HAVE_FF = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    localparam int OB = jmss_pkg::OFFSET_BITS;

    logic [OB-1:0]  pos_reg, pos_next;
    logic [2:0]     phase_reg, phase_next;
    logic [15:0]    skip_reg, skip_next;
    logic [7:0]     held_code_reg, held_code_next;
    logic [OB-1:0]  held_off_reg, held_off_next;
    logic [7:0]     len_hi_reg, len_hi_next;
    logic [OB-1:0]  soi0_reg, soi0_next, soi1_reg, soi1_next;
    logic [OB-1:0]  eoi0_reg, eoi0_next, eoi1_reg, eoi1_next;
    logic [1:0]     soi_cnt_reg, soi_cnt_next, eoi_cnt_reg, eoi_cnt_next;
    logic           four_reg, four_next;

    logic           accept;
    logic [7:0]     b;
    logic           mk_valid;
    logic [7:0]     mk_code;
    logic [OB-1:0]  mk_off;
    logic [15:0]    mk_len;
    logic [15:0]    full_len;
    logic [15:0]    skip_dec;
    logic [OB-1:0]  eoi_end;
    logic [1:0]     st;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;
    assign b          = byte_item.data_byte;
    assign full_len   = {len_hi_reg, b};
    assign skip_dec   = skip_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        held_code_next = held_code_reg;
        held_off_next  = held_off_reg;
        len_hi_next    = len_hi_reg;
        mk_valid       = 1'b0;
        mk_code        = held_code_reg;
        mk_off         = held_off_reg;
        mk_len         = 16'd0;

        unique case (phase_reg)
            PH_HAVE_FF:
            begin
                if (b == jmss_pkg::BYTE_ZERO)
                begin
                    phase_next = PH_SEARCH;
                end
                else if (b >= jmss_pkg::RST0_CODE && b <= jmss_pkg::EOI_CODE)
                begin
                    // standalone markers carry no length
                    mk_valid   = 1'b1;
                    mk_code    = b;
                    phase_next = PH_SEARCH;
                end
                else
                begin
                    held_code_next = b;
                    phase_next     = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = b;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                mk_valid = 1'b1;
                mk_len   = full_len;
                if (full_len >= 16'd3)
                begin
                    skip_next  = full_len - 16'd2;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    // lengths 0 to 2 leave nothing to skip
                    phase_next = PH_SEARCH;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_SEARCH;
                end
            end
            default:
            begin
                if (b == jmss_pkg::BYTE_FF)
                begin
                    held_off_next = pos_reg;
                    phase_next    = PH_HAVE_FF;
                end
                else
                begin
                    phase_next = PH_SEARCH;
                end
            end
        endcase

        // length bytes cut off by the end of the file
        if (byte_item.is_last && (phase_next == PH_LEN_HI || phase_next == PH_LEN_LO))
        begin
            mk_valid = 1'b1;
            mk_code  = held_code_next;
            mk_off   = held_off_next;
            mk_len   = 16'd0;
        end
    end

    assign eoi_end = mk_off + OB'(2);

    always_comb
    begin
        soi0_next    = soi0_reg;
        soi1_next    = soi1_reg;
        eoi0_next    = eoi0_reg;
        eoi1_next    = eoi1_reg;
        soi_cnt_next = soi_cnt_reg;
        eoi_cnt_next = eoi_cnt_reg;
        if (mk_valid && mk_code == jmss_pkg::SOI_CODE && soi_cnt_reg < 2'd2)
        begin
            if (soi_cnt_reg == 2'd0)
            begin
                soi0_next = mk_off;
            end
            else
            begin
                soi1_next = mk_off;
            end
            soi_cnt_next = soi_cnt_reg + 2'd1;
        end
        if (mk_valid && mk_code == jmss_pkg::EOI_CODE && eoi_cnt_reg < 2'd2)
        begin
            if (eoi_cnt_reg == 2'd0)
            begin
                eoi0_next = eoi_end;
            end
            else
            begin
                eoi1_next = eoi_end;
            end
            eoi_cnt_next = eoi_cnt_reg + 2'd1;
        end
    end

    assign four_next = four_reg || (pos_reg == jmss_pkg::FOURTH_BYTE_POS);

    always_comb
    begin
        if (!four_next)
        begin
            st = jmss_pkg::STATUS_SHORT;
        end
        else if (soi_cnt_next == 2'd0 || eoi_cnt_next == 2'd0)
        begin
            st = jmss_pkg::STATUS_NONE;
        end
        else if (soi_cnt_next < 2'd2 || eoi_cnt_next < 2'd2)
        begin
            st = jmss_pkg::STATUS_BASE;
        end
        else
        begin
            st = jmss_pkg::STATUS_BOTH;
        end
    end

    always_comb
    begin
        push_event                = '0;
        push_event.has_marker     = mk_valid;
        push_event.marker_code    = mk_code;
        push_event.marker_offset  = mk_off;
        push_event.segment_length = mk_len;
        push_event.has_summary    = byte_item.is_last;
        push_event.status         = st;
        if (st == jmss_pkg::STATUS_BASE || st == jmss_pkg::STATUS_BOTH)
        begin
            push_event.first_start = soi0_next;
            push_event.first_end   = eoi0_next;
        end
        if (st == jmss_pkg::STATUS_BOTH)
        begin
            push_event.second_start = soi1_next;
            push_event.second_end   = eoi1_next;
        end
    end

    assign push     = accept && (mk_valid || byte_item.is_last);
    assign pos_next = pos_reg + OB'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_SEARCH;
            skip_reg      <= '0;
            held_code_reg <= '0;
            held_off_reg  <= '0;
            len_hi_reg    <= '0;
            soi0_reg      <= '0;
            soi1_reg      <= '0;
            eoi0_reg      <= '0;
            eoi1_reg      <= '0;
            soi_cnt_reg   <= '0;
            eoi_cnt_reg   <= '0;
            four_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (byte_item.is_last)
            begin
                // file done, next byte starts a new one
                pos_reg       <= '0;
                phase_reg     <= PH_SEARCH;
                skip_reg      <= '0;
                held_code_reg <= '0;
                held_off_reg  <= '0;
                len_hi_reg    <= '0;
                soi0_reg      <= '0;
                soi1_reg      <= '0;
                eoi0_reg      <= '0;
                eoi1_reg      <= '0;
                soi_cnt_reg   <= '0;
                eoi_cnt_reg   <= '0;
                four_reg      <= 1'b0;
            end
            else
            begin
                pos_reg       <= pos_next;
                phase_reg     <= phase_next;
                skip_reg      <= skip_next;
                held_code_reg <= held_code_next;
                held_off_reg  <= held_off_next;
                len_hi_reg    <= len_hi_next;
                soi0_reg      <= soi0_next;
                soi1_reg      <= soi1_next;
                eoi0_reg      <= eoi0_next;
                eoi1_reg      <= eoi1_next;
                soi_cnt_reg   <= soi_cnt_next;
                eoi_cnt_reg   <= eoi_cnt_next;
                four_reg      <= four_next;
            end
        end
    end

endmodule

>>> hdl/jmss_queue.sv
// ============================================================================
// jmss_queue
// Short event queue between the scanner and the record output stage.
// ============================================================================
module jmss_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  jmss_pkg::scan_event_t   push_event,
    input  logic                    pop,
    output jmss_pkg::scan_event_t   head_event,
    output jmss_pkg::queue_status_t q_status
);

    localparam int PB = jmss_pkg::QUEUE_PTR_BITS;

    jmss_pkg::scan_event_t slots_reg [jmss_pkg::QUEUE_DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PB:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign q_status.full  = (count_reg == (PB+1)'(jmss_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_event     = slots_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PB'(jmss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PB'(1);
    assign rd_ptr_next = (rd_ptr_reg == PB'(jmss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PB'(1);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PB+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PB+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_event;
        end
    end

endmodule

>>> hdl/jmss_back.sv
// ============================================================================
// jmss_back
// Record output stage: holds one event and hands out its marker record
// and its summary record as separate beats.
// ============================================================================
module jmss_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  jmss_pkg::scan_event_t   head_event,
    input  jmss_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    rec_valid,
    input  logic                    rec_ready,
    output jmss_pkg::rec_item_t     rec_item
);

    jmss_pkg::scan_event_t cur_reg;
    logic                  cur_valid_reg;
    logic                  sum_phase_reg;

    logic show_marker;
    logic taken;
    logic done;
    logic load;

    assign show_marker = cur_reg.has_marker && !sum_phase_reg;
    assign rec_valid   = cur_valid_reg;
    assign taken       = rec_valid && rec_ready;
    // an event with both parts needs a second beat
    assign done        = taken && !(show_marker && cur_reg.has_summary);
    assign load        = !cur_valid_reg || done;
    assign pop         = load && !q_status.empty;

    always_comb
    begin
        rec_item = '0;
        if (show_marker)
        begin
            rec_item.record_kind    = jmss_pkg::KIND_MARKER;
            rec_item.marker_code    = cur_reg.marker_code;
            rec_item.marker_offset  = cur_reg.marker_offset;
            rec_item.segment_length = cur_reg.segment_length;
            rec_item.last_of_run    = !cur_reg.has_summary;
        end
        else
        begin
            rec_item.record_kind  = jmss_pkg::KIND_SUMMARY;
            rec_item.first_start  = cur_reg.first_start;
            rec_item.first_end    = cur_reg.first_end;
            rec_item.second_start = cur_reg.second_start;
            rec_item.second_end   = cur_reg.second_end;
            rec_item.status       = cur_reg.status;
            rec_item.last_of_run  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sum_phase_reg <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= !q_status.empty;
            sum_phase_reg <= 1'b0;
        end
        else if (taken)
        begin
            sum_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_event;
        end
    end

endmodule

>>> hdl/jpeg_marker_scan_splitter_core.sv
// ============================================================================
// jpeg_marker_scan_splitter_core
// Scans a JPEG byte stream, one byte per beat, and reports every marker
// with its offset, code and segment length, then an end-of-file summary
// with the first two SOI offsets, the first two EOI ends and a status.
// The scanner takes one byte per clock while the queue has room; a byte that
// yields output puts one event into a four-entry queue, and the output stage
// sends one record per clock while rec_ready is high, so a final byte that
// also closes a marker costs two output records. The queue absorbs that and
// short stalls; byte_ready drops only while the queue is full.
// ============================================================================
module jpeg_marker_scan_splitter_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  jmss_pkg::byte_item_t byte_item,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output jmss_pkg::rec_item_t  rec_item
);

    jmss_pkg::scan_event_t   push_event;
    jmss_pkg::scan_event_t   head_event;
    jmss_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    jmss_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_event (push_event)
    );

    jmss_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .head_event (head_event),
        .q_status   (q_status)
    );

    jmss_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_event (head_event),
        .q_status   (q_status),
        .pop        (pop),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_item   (rec_item)
    );

endmodule
